[hdl/pce_pkg.sv]
package pce_pkg;

   // block geometry
   localparam int PART_SIZE      = 256;
   localparam int MAX_PARTITIONS = 16;
   localparam int SAMPLE_BITS    = 24;

   localparam int TAP_DEPTH  = MAX_PARTITIONS * PART_SIZE;
   localparam int HIST_DEPTH = (MAX_PARTITIONS + 1) * PART_SIZE;
   localparam int TAP_AW     = $clog2(TAP_DEPTH);
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int HIST_RING  = 1 << HIST_AW;
   localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);
   localparam int PART_AW    = $clog2(PART_SIZE);
   localparam int NPART_W    = 5;
   localparam int COEF_IDX_W = 12;
   localparam int ACC_W      = 64;
   localparam int PROD_W     = 2 * SAMPLE_BITS;

   // action codes
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_COEF   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // register addresses
   localparam int REG_PART_COUNT = 0;

   // one issued multiply-accumulate step
   typedef struct packed {
      logic               vld;
      logic               first;
      logic               last;
      logic               zero;
      logic [PART_AW-1:0] idx;
   } mac_ctl_type;

   // output block write port
   typedef struct packed {
      logic                   en;
      logic [PART_AW-1:0]     addr;
      logic [SAMPLE_BITS-1:0] data;
   } out_wr_type;

endpackage

[hdl/pce_ram.sv]
module pce_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pce_mac.sv]
module pce_mac import pce_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctl_type                   issue,
   input  logic signed [SAMPLE_BITS-1:0] coef,
   input  logic signed [SAMPLE_BITS-1:0] hist,
   output out_wr_type                    out_wr,
   output logic                          busy
);

   localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (SAMPLE_BITS - 2);
   localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] MINV = -(ACC_W'(1) << (SAMPLE_BITS - 1));

   mac_ctl_type ctl0_ff, ctl1_ff, ctl2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  rnd, shf;
   logic [SAMPLE_BITS-1:0]   sat;
   logic                     wr_en_ff;
   logic [PART_AW-1:0]       wr_addr_ff;
   logic [SAMPLE_BITS-1:0]   wr_data_ff;

   // control pipeline, aligned with RAM read latency
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff  <= '0;
         ctl1_ff  <= '0;
         ctl2_ff  <= '0;
         wr_en_ff <= 1'b0;
      end else begin
         ctl0_ff  <= issue;
         ctl1_ff  <= ctl0_ff;
         ctl2_ff  <= ctl1_ff;
         wr_en_ff <= ctl2_ff.vld && ctl2_ff.last;
      end
   end

   // accumulate, round, saturate
   always_comb begin
      acc_in = ctl1_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      rnd = acc_ff + RND;
      shf = rnd >>> (SAMPLE_BITS - 1);
      if (shf > MAXV) begin
         sat = MAXV[SAMPLE_BITS-1:0];
      end else if (shf < MINV) begin
         sat = MINV[SAMPLE_BITS-1:0];
      end else begin
         sat = shf[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl0_ff.zero) begin
         prod_ff <= '0;
      end else begin
         prod_ff <= coef * hist;
      end
      if (ctl1_ff.vld) begin
         acc_ff <= acc_in;
      end
      wr_addr_ff <= ctl2_ff.idx;
      wr_data_ff <= sat;
   end

   assign out_wr = '{en: wr_en_ff, addr: wr_addr_ff, data: wr_data_ff};
   assign busy   = ctl0_ff.vld || ctl1_ff.vld || ctl2_ff.vld || wr_en_ff;

endmodule

[hdl/partitioned_convolution_engine_core.sv]
// channel   dir  handshake            payload
// req       in   req_tvalid/tready    tdata: action, coef_index, coef_value, sample
// rsp       out  rsp_tvalid/tready    tdata: out_sample
// csr       in   APB psel/penable     partition count at byte address 0
//
// Coefficient loads and clears complete in the idle state. A sample passes through
// ST_OUTRD, where it waits on any output stall. The sample that completes a block then
// runs the shared multiplier over PART_SIZE * taps steps, then drains the MAC pipeline.
// After reset the coefficient store is swept to zero, with req not ready.
// History beyond the samples written since the last clear reads as zero.
module partitioned_convolution_engine_core import pce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // action[1:0] coef_index[13:2] coef_value[37:14] sample[61:38]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_sample[23:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_OUTRD = 3'd2;
   localparam logic [2:0] ST_MAC   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [TAP_AW-1:0]      init_ff, init_in;
   logic [HIST_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [HIST_CW-1:0]     fill_ff, fill_in;
   logic [PART_AW-1:0]     pos_ff, pos_in;
   logic                   finish_ff, finish_in;
   logic                   out_ok_ff, out_ok_in;
   logic [NPART_W-1:0]     nparts_ff;
   logic [PART_AW-1:0]     j_ff, j_in;
   logic [TAP_AW-1:0]      k_ff, k_in;
   logic [TAP_AW-1:0]      tap_last_ff, tap_last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [1:0]             action;
   logic [COEF_IDX_W-1:0]  coef_index;
   logic [SAMPLE_BITS-1:0] coef_value, sample;
   logic                   req_xfer, csr_wr;
   logic [NPART_W-1:0]     parts;
   logic [HIST_CW-1:0]     age;

   logic                   coef_we;
   logic [TAP_AW-1:0]      coef_waddr;
   logic [SAMPLE_BITS-1:0] coef_wdata, coef_rdata, hist_rdata, out_rdata;
   logic                   hist_we;
   logic [HIST_AW-1:0]     hist_raddr;
   logic [PART_AW-1:0]     out_raddr;
   mac_ctl_type            issue;
   out_wr_type             out_wr;
   logic                   mac_busy;

   assign action     = req_tdata[1:0];
   assign coef_index = req_tdata[13:2];
   assign coef_value = req_tdata[37:14];
   assign sample     = req_tdata[61:38];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == 3'(4 * REG_PART_COUNT)) ? 32'(nparts_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         nparts_ff <= NPART_W'(1);
      end else if (csr_wr && csr_paddr == 3'(4 * REG_PART_COUNT)) begin
         nparts_ff <= csr_pwdata[NPART_W-1:0];
      end
   end

   // partitions in use
   always_comb begin
      if (nparts_ff == '0) begin
         parts = NPART_W'(1);
      end else if (int'(nparts_ff) > MAX_PARTITIONS) begin
         parts = NPART_W'(MAX_PARTITIONS);
      end else begin
         parts = nparts_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      wr_ptr_in    = wr_ptr_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      finish_in    = finish_ff;
      out_ok_in    = out_ok_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      tap_last_in  = tap_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      coef_we      = 1'b0;
      coef_waddr   = init_ff;
      coef_wdata   = '0;
      hist_we      = 1'b0;
      issue        = '0;
      age          = HIST_CW'(PART_SIZE - 1) - HIST_CW'(j_ff) + HIST_CW'(k_ff);
      hist_raddr   = wr_ptr_ff - HIST_AW'(PART_SIZE) + HIST_AW'(j_ff) - HIST_AW'(k_ff);
      out_raddr    = (state_ff == ST_IDLE) ? pos_ff : pos_ff - PART_AW'(1);
      if (finish_ff && state_ff == ST_OUTRD) begin
         out_raddr = PART_AW'(PART_SIZE - 1);
      end

      case (state_ff)
         ST_INIT: begin
            coef_we = 1'b1;
            init_in = init_ff + TAP_AW'(1);
            if (int'(init_ff) == TAP_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               case (action)
                  ACT_SAMPLE: begin
                     hist_we   = 1'b1;
                     wr_ptr_in = wr_ptr_ff + HIST_AW'(1);
                     if (int'(fill_ff) < HIST_DEPTH) begin
                        fill_in = fill_ff + HIST_CW'(1);
                     end
                     if (int'(pos_ff) == PART_SIZE - 1) begin
                        pos_in    = '0;
                        finish_in = 1'b1;
                     end else begin
                        pos_in = pos_ff + PART_AW'(1);
                     end
                     state_in = ST_OUTRD;
                  end
                  ACT_COEF: begin
                     if (int'(coef_index) < TAP_DEPTH) begin
                        coef_we    = 1'b1;
                        coef_waddr = TAP_AW'(coef_index);
                        coef_wdata = coef_value;
                     end
                  end
                  ACT_CLEAR: begin
                     fill_in   = '0;
                     pos_in    = '0;
                     out_ok_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_OUTRD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = out_ok_ff ? out_rdata : '0;
               if (finish_ff) begin
                  finish_in   = 1'b0;
                  j_in        = '0;
                  k_in        = '0;
                  tap_last_in = TAP_AW'(int'(parts) * PART_SIZE - 1);
                  state_in    = ST_MAC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MAC: begin
            issue.vld   = 1'b1;
            issue.first = (k_ff == '0);
            issue.last  = (k_ff == tap_last_ff);
            issue.zero  = (age >= fill_ff);
            issue.idx   = j_ff;
            if (k_ff == tap_last_ff) begin
               k_in = '0;
               if (int'(j_ff) == PART_SIZE - 1) begin
                  state_in = ST_DRAIN;
               end else begin
                  j_in = j_ff + PART_AW'(1);
               end
            end else begin
               k_in = k_ff + TAP_AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               out_ok_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         finish_ff    <= 1'b0;
         out_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         finish_ff    <= finish_in;
         out_ok_ff    <= out_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      k_ff        <= k_in;
      tap_last_ff <= tap_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // stores
   pce_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAP_DEPTH)) u_coef (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_addr (k_ff),
      .rd_data (coef_rdata)
   );

   pce_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HIST_RING)) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (sample),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   pce_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(PART_SIZE)) u_out (
      .clock   (clock),
      .wr_en   (out_wr.en),
      .wr_addr (out_wr.addr),
      .wr_data (out_wr.data),
      .rd_addr (out_raddr),
      .rd_data (out_rdata)
   );

   // shared multiply-accumulate
   pce_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .coef   (coef_rdata),
      .hist   (hist_rdata),
      .out_wr (out_wr),
      .busy   (mac_busy)
   );

endmodule

[tb/partitioned_convolution_engine_core_checker.sv]
// Watches the request, result and register channels, keeps a bit-exact
// model of the convolver and compares each result transfer in order.
module partitioned_convolution_engine_core_checker import pce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          pending
);

   localparam longint SAT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

   longint                 taps_q [TAP_DEPTH];
   longint                 hist_q [HIST_DEPTH];
   logic [SAMPLE_BITS-1:0] prev_block [PART_SIZE];
   int                     fill_pos;
   int                     block_ctr;
   logic [NPART_W-1:0]     npart_reg;
   logic [SAMPLE_BITS-1:0] out_fifo [$];

   function automatic int parts_used();
      if (npart_reg == 0) return 1;
      if (npart_reg > MAX_PARTITIONS) return MAX_PARTITIONS;
      return npart_reg;
   endfunction

   // round half up, then clamp to the sample range
   function automatic logic [SAMPLE_BITS-1:0] round_clamp(input longint acc);
      longint r;
      r = (acc + (64'sd1 <<< (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
      if (r > SAT_MAX) r = SAT_MAX;
      if (r < SAT_MIN) r = SAT_MIN;
      return r[SAMPLE_BITS-1:0];
   endfunction

   // full linear convolution of the block just filled, then shift history
   function automatic void close_block();
      int     ntaps;
      int     base;
      longint acc;
      ntaps = parts_used() * PART_SIZE;
      for (int j = 0; j < PART_SIZE; j++) begin
         acc = 0;
         base = HIST_DEPTH - PART_SIZE + j;
         for (int k = 0; k < ntaps; k++)
            acc += taps_q[k] * hist_q[base - k];
         prev_block[j] = round_clamp(acc);
      end
      for (int i = 0; i < HIST_DEPTH - PART_SIZE; i++)
         hist_q[i] = hist_q[i + PART_SIZE];
      for (int i = HIST_DEPTH - PART_SIZE; i < HIST_DEPTH; i++)
         hist_q[i] = 0;
      block_ctr = (block_ctr + 1) % parts_used();
   endfunction

   function automatic void wipe_history();
      foreach (hist_q[i]) hist_q[i] = 0;
      foreach (prev_block[i]) prev_block[i] = '0;
      fill_pos = 0;
      block_ctr = 0;
   endfunction

   function automatic void apply_request(input logic [63:0] d);
      logic [1:0]             act;
      logic [COEF_IDX_W-1:0]  idx;
      logic signed [23:0]     cval;
      logic signed [23:0]     sval;
      act  = d[1:0];
      idx  = d[13:2];
      cval = d[37:14];
      sval = d[61:38];
      case (act)
         ACT_COEF: begin
            if (idx < TAP_DEPTH) taps_q[idx] = cval;
         end
         ACT_CLEAR: wipe_history();
         ACT_SAMPLE: begin
            if (fill_pos >= PART_SIZE) fill_pos = 0;
            out_fifo.push_back(prev_block[fill_pos]);
            hist_q[HIST_DEPTH - PART_SIZE + fill_pos] = sval;
            fill_pos++;
            if (fill_pos >= PART_SIZE) begin
               close_block();
               fill_pos = 0;
            end
         end
         default: ;
      endcase
   endfunction

   initial begin
      errors = 0;
      foreach (taps_q[i]) taps_q[i] = 0;
      wipe_history();
      npart_reg = 1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         // result transfer
         if (rsp_tvalid && rsp_tready) begin
            if (out_fifo.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               if (rsp_tdata !== out_fifo[0]) begin
                  $display("%0t out_sample mismatch: expected %h, actual %h",
                           $time, out_fifo[0], rsp_tdata);
                  errors++;
               end
               void'(out_fifo.pop_front());
            end
         end
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == 3'(4 * REG_PART_COUNT))
               npart_reg = csr_pwdata[NPART_W-1:0];
         end
         // request transfer
         if (req_tvalid && req_tready)
            apply_request(req_tdata);
      end
      pending <= out_fifo.size();
   end

endmodule

[tb/partitioned_convolution_engine_core_test.sv]
module partitioned_convolution_engine_core_test import pce_pkg::*; ();

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // action[1:0] coef_index[13:2] coef_value[37:14] sample[61:38]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;        // out_sample[23:0]
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int errors;
   int pending;

   // stimulus-side bookkeeping
   bit idle_on = 1;
   bit hold_req = 0;
   int eff_parts = 1;
   int blk_fill = 0;
   int last_blk_parts = 1;
   bit blk_done = 0;

   always #2 clock = ~clock;

   partitioned_convolution_engine_core u_top (.*);

   partitioned_convolution_engine_core_checker u_check (.*);

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_req = 0;
         end else begin
            rsp_tready <= !idle_on || ($urandom_range(99) >= 34);
         end
      end
   end

   function automatic logic [23:0] pick_value();
      case ($urandom_range(9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return $urandom_range(1) ? 24'h000000 : 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pack(input logic [1:0] act, input logic [11:0] idx,
                                        input logic [23:0] cval, input logic [23:0] sval);
      return {2'b00, sval, cval, idx, act};
   endfunction

   function automatic logic [63:0] random_item(input int span);
      int          r;
      logic [11:0] idx;
      logic [1:0]  act;
      r = $urandom_range(999);
      if (r < 830) act = ACT_SAMPLE;
      else if (r < 965) act = ACT_COEF;
      else if (r < 985) act = ACT_UNUSED;
      else if (r < 988) act = ACT_CLEAR;
      else act = ACT_SAMPLE;
      if ($urandom_range(9) < 7) idx = 12'($urandom_range(span * PART_SIZE - 1));
      else idx = 12'($urandom_range(4095));
      return pack(act, idx, pick_value(), pick_value());
   endfunction

   task automatic push(input logic [63:0] d);
      if (idle_on && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // track block fill to know how long the block may compute
      if (d[1:0] == ACT_CLEAR) blk_fill = 0;
      else if (d[1:0] == ACT_SAMPLE) begin
         blk_fill++;
         if (blk_fill == PART_SIZE) begin
            blk_fill = 0;
            last_blk_parts = eff_parts;
            blk_done = 1;
         end
      end
   endtask

   // wait for idle: all results back, and any block computation drained
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      if (blk_done) repeat (last_blk_parts * PART_SIZE * PART_SIZE + 256) @(posedge clock);
      else repeat (64) @(posedge clock);
      blk_done = 0;
   endtask

   task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == 3'(4 * REG_PART_COUNT)) begin
         eff_parts = val[4:0];
         if (eff_parts == 0) eff_parts = 1;
         if (eff_parts > MAX_PARTITIONS) eff_parts = MAX_PARTITIONS;
      end
   endtask

   task automatic random_run(input int n);
      for (int i = 0; i < n; i++) push(random_item(eff_parts));
   endtask

   initial begin
      #(4 * 20_000_000);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // coefficient sweep after reset holds req off
      @(posedge clock);
      while (!req_tready) @(posedge clock);

      reg_write(3'd4, 32'd5);   // no register there
      reg_write(3'd0, 32'd1);

      // directed: tap and sample extremes, every action
      push(pack(ACT_COEF, 12'd0, 24'h7FFFFF, 24'h123456));
      push(pack(ACT_COEF, 12'd1, 24'h7FFFFF, 24'hFFFFFF));
      push(pack(ACT_COEF, 12'd2, 24'h800000, 24'h000000));
      push(pack(ACT_COEF, 12'd255, 24'h000001, 24'hABCDEF));
      push(pack(ACT_COEF, 12'd4095, 24'h7FFFFF, 24'h800000));
      push(pack(ACT_COEF, 12'd256, 24'hFFFFFF, 24'h7FFFFF));
      push(pack(ACT_UNUSED, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF));
      push(pack(ACT_SAMPLE, 12'hFFF, 24'hFFFFFF, 24'h7FFFFF));
      push(pack(ACT_SAMPLE, 12'h000, 24'h000000, 24'h7FFFFF));
      push(pack(ACT_SAMPLE, 12'h000, 24'h000000, 24'h800000));
      push(pack(ACT_SAMPLE, 12'h000, 24'h000000, 24'h000000));
      push(pack(ACT_SAMPLE, 12'h000, 24'h000000, 24'hFFFFFF));
      push(pack(ACT_CLEAR, 12'h5A5, 24'h5A5A5A, 24'hA5A5A5));
      push(pack(ACT_SAMPLE, 12'h000, 24'h000000, 24'h7FFFFF));
      push(pack(ACT_SAMPLE, 12'h000, 24'h000000, 24'h7FFFFF));
      push(pack(ACT_SAMPLE, 12'h000, 24'h000000, 24'h800000));
      push(pack(ACT_UNUSED, 12'h000, 24'h000000, 24'h000000));

      // one partition, with a long receiver hold-off early on
      hold_req = 1;
      random_run(350);
      settle();

      // two partitions, first with both sides never idle, then with idle gaps
      reg_write(3'd0, 32'd2);
      idle_on = 0;
      random_run(150);
      idle_on = 1;
      random_run(100);
      settle();

      // zero partitions behaves as one
      reg_write(3'd0, 32'd0);
      random_run(200);
      settle();

      // out-of-range count clamps to the maximum: complete one block there
      reg_write(3'd0, 32'd31);
      while (!blk_done) push(random_item(MAX_PARTITIONS));
      settle();

      // back to one partition, drain the wide block's outputs
      reg_write(3'd0, 32'd1);
      random_run(150);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/pce_pkg.sv
hdl/pce_ram.sv
hdl/pce_mac.sv
hdl/partitioned_convolution_engine_core.sv
tb/partitioned_convolution_engine_core_checker.sv
tb/partitioned_convolution_engine_core_test.sv
